// File: hdl/cmfs_pkg.sv
package cmfs_pkg;

    // Default widths of the direction components and of the face coordinates.
    localparam int COMPONENT_BITS_DEF = 16;
    localparam int COORD_BITS_DEF     = 16;

    // Cube face codes, in the usual +x, -x, +y, -y, +z, -z order.
    typedef enum logic [2:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } face_t;

endpackage

// File: hdl/cmfs_front.sv
module cmfs_front #(
    parameter int COMPONENT_BITS = cmfs_pkg::COMPONENT_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [COMPONENT_BITS-1:0]   dir_x,
    input  logic [COMPONENT_BITS-1:0]   dir_y,
    input  logic [COMPONENT_BITS-1:0]   dir_z,
    output logic                        cls_valid,
    input  logic                        cls_ready,
    output cmfs_pkg::face_t             cls_face,
    output logic                        cls_zero,
    output logic [COMPONENT_BITS-1:0]   cls_ma,
    output logic [COMPONENT_BITS:0]     cls_sc,
    output logic [COMPONENT_BITS:0]     cls_tc
);

    localparam int N = COMPONENT_BITS;

    logic                 valid_reg;
    logic                 valid_next;
    cmfs_pkg::face_t      face_reg;
    cmfs_pkg::face_t      face_next;
    logic                 zero_reg;
    logic                 zero_next;
    logic [N-1:0]         ma_reg;
    logic [N-1:0]         ma_next;
    logic [N:0]           sc_reg;
    logic [N:0]           sc_next;
    logic [N:0]           tc_reg;
    logic [N:0]           tc_next;

    logic [N-1:0]         ax;
    logic [N-1:0]         ay;
    logic [N-1:0]         az;
    logic [N:0]           ex;
    logic [N:0]           ey;
    logic [N:0]           ez;
    logic [N:0]           nz;
    logic                 x_pos;
    logic                 y_pos;
    logic                 z_pos;
    logic                 take;

    // Magnitudes fit in N unsigned bits, including the most negative value.
    assign ax = dir_x[N-1] ? N'(~dir_x + 1'b1) : dir_x;
    assign ay = dir_y[N-1] ? N'(~dir_y + 1'b1) : dir_y;
    assign az = dir_z[N-1] ? N'(~dir_z + 1'b1) : dir_z;

    assign ex = {dir_x[N-1], dir_x};
    assign ey = {dir_y[N-1], dir_y};
    assign ez = {dir_z[N-1], dir_z};
    assign nz = (N+1)'(~ez + 1'b1);

    assign x_pos = !dir_x[N-1] && (dir_x != '0);
    assign y_pos = !dir_y[N-1] && (dir_y != '0);
    assign z_pos = !dir_z[N-1] && (dir_z != '0);

    assign in_ready = !valid_reg || cls_ready;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        face_next  = face_reg;
        zero_next  = zero_reg;
        ma_next    = ma_reg;
        sc_next    = sc_reg;
        tc_next    = tc_reg;
        if (cls_ready)
        begin
            valid_next = 1'b0;
        end
        if (take)
        begin
            valid_next = 1'b1;
            // X wins only when strictly largest; a y/z tie goes to z.
            if ((ax > ay) && (ax > az))
            begin
                ma_next = ax;
                tc_next = ey;
                if (x_pos)
                begin
                    face_next = cmfs_pkg::FACE_POS_X;
                    sc_next   = ez;
                end
                else
                begin
                    face_next = cmfs_pkg::FACE_NEG_X;
                    sc_next   = nz;
                end
            end
            else if (ay > az)
            begin
                ma_next = ay;
                sc_next = ex;
                if (y_pos)
                begin
                    face_next = cmfs_pkg::FACE_POS_Y;
                    tc_next   = ez;
                end
                else
                begin
                    face_next = cmfs_pkg::FACE_NEG_Y;
                    tc_next   = nz;
                end
            end
            else
            begin
                ma_next = az;
                tc_next = ey;
                if (z_pos)
                begin
                    face_next = cmfs_pkg::FACE_POS_Z;
                    sc_next   = (N+1)'(~ex + 1'b1);
                end
                else
                begin
                    face_next = cmfs_pkg::FACE_NEG_Z;
                    sc_next   = ex;
                end
            end
            zero_next = (ma_next == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        face_reg <= face_next;
        zero_reg <= zero_next;
        ma_reg   <= ma_next;
        sc_reg   <= sc_next;
        tc_reg   <= tc_next;
    end

    assign cls_valid = valid_reg;
    assign cls_face  = face_reg;
    assign cls_zero  = zero_reg;
    assign cls_ma    = ma_reg;
    assign cls_sc    = sc_reg;
    assign cls_tc    = tc_reg;

endmodule

// File: hdl/cmfs_queue.sv
module cmfs_queue #(
    parameter int WIDTH = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [WIDTH-1:0]  push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [WIDTH-1:0]  pop_data
);

    // Two entries let the queue absorb a stall on either side.
    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

// File: hdl/cmfs_divider.sv
module cmfs_divider #(
    parameter int COMPONENT_BITS = cmfs_pkg::COMPONENT_BITS_DEF,
    parameter int COORD_BITS     = cmfs_pkg::COORD_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  cmfs_pkg::face_t             in_face,
    input  logic                        in_zero,
    input  logic [COMPONENT_BITS-1:0]   in_ma,
    input  logic [COMPONENT_BITS:0]     in_sc,
    input  logic [COMPONENT_BITS:0]     in_tc,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [2:0]                  face,
    output logic [COORD_BITS-1:0]       u_coord,
    output logic [COORD_BITS-1:0]       v_coord,
    output logic                        zero_vector
);

    localparam int N = COMPONENT_BITS;
    localparam int C = COORD_BITS;
    localparam int STAGES = C + 1;

    typedef struct packed {
        cmfs_pkg::face_t face;
        logic            zero;
        logic            sat_u;
        logic            sat_v;
        logic [N:0]      d;
        logic [N:0]      r_u;
        logic [N:0]      r_v;
        logic [C-1:0]    q_u;
        logic [C-1:0]    q_v;
    } stage_t;

    stage_t         st_reg   [STAGES];
    stage_t         st_next  [STAGES];
    logic           vld_reg  [STAGES];
    logic           vld_next [STAGES];
    logic           advance;
    logic [N+1:0]   t_u_wide;
    logic [N+1:0]   t_v_wide;
    logic [N+1:0]   r2_u;
    logic [N+1:0]   r2_v;
    logic [N+1:0]   d_wide;

    // The whole pipeline moves as one; it holds only when the result waits.
    assign advance  = !vld_reg[STAGES-1] || out_ready;
    assign in_ready = advance;

    // Offset each minor component by the major magnitude: 0 <= t <= 2*ma.
    assign t_u_wide = {in_sc[N], in_sc} + {2'b00, in_ma};
    assign t_v_wide = {in_tc[N], in_tc} + {2'b00, in_ma};

    always_comb
    begin
        r2_u   = '0;
        r2_v   = '0;
        d_wide = '0;
        st_next[0].face  = in_face;
        st_next[0].zero  = in_zero;
        st_next[0].d     = {in_ma, 1'b0};
        st_next[0].r_u   = t_u_wide[N:0];
        st_next[0].r_v   = t_v_wide[N:0];
        st_next[0].sat_u = (t_u_wide[N:0] == {in_ma, 1'b0});
        st_next[0].sat_v = (t_v_wide[N:0] == {in_ma, 1'b0});
        st_next[0].q_u   = '0;
        st_next[0].q_v   = '0;
        vld_next[0]      = in_valid;
        // One restoring-division step per stage, most significant bit first.
        for (int k = 1; k < STAGES; k++)
        begin
            st_next[k]  = st_reg[k-1];
            vld_next[k] = vld_reg[k-1];
            d_wide = {1'b0, st_reg[k-1].d};
            r2_u   = {st_reg[k-1].r_u, 1'b0};
            r2_v   = {st_reg[k-1].r_v, 1'b0};
            if (r2_u >= d_wide)
            begin
                r2_u = r2_u - d_wide;
                st_next[k].q_u = {st_reg[k-1].q_u[C-2:0], 1'b1};
            end
            else
            begin
                st_next[k].q_u = {st_reg[k-1].q_u[C-2:0], 1'b0};
            end
            if (r2_v >= d_wide)
            begin
                r2_v = r2_v - d_wide;
                st_next[k].q_v = {st_reg[k-1].q_v[C-2:0], 1'b1};
            end
            else
            begin
                st_next[k].q_v = {st_reg[k-1].q_v[C-2:0], 1'b0};
            end
            st_next[k].r_u = r2_u[N:0];
            st_next[k].r_v = r2_v[N:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (advance)
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                vld_reg[k] <= vld_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    // A zero vector reports the face center; an exact 1.0 saturates.
    assign out_valid   = vld_reg[STAGES-1];
    assign face        = st_reg[STAGES-1].face;
    assign zero_vector = st_reg[STAGES-1].zero;
    assign u_coord     = st_reg[STAGES-1].zero  ? {1'b1, {(C-1){1'b0}}} :
                         st_reg[STAGES-1].sat_u ? {C{1'b1}} : st_reg[STAGES-1].q_u;
    assign v_coord     = st_reg[STAGES-1].zero  ? {1'b1, {(C-1){1'b0}}} :
                         st_reg[STAGES-1].sat_v ? {C{1'b1}} : st_reg[STAGES-1].q_v;

    a_zero_face: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && zero_vector) |-> (face == cmfs_pkg::FACE_NEG_Z))
        else $error("zero vector reported on a face other than -z");

    a_entry_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[0] && !advance) |=> (vld_reg[0] && $stable(st_reg[0])))
        else $error("pipeline entry changed during a stall");

endmodule

// File: hdl/cube_map_face_uv_select_top.sv
// Cube map face selection with face coordinates u and v in Q0.COORD_BITS.
// A transaction is registered in the front, then in the queue, then in each divider stage.
// Throughput: one transaction per cycle while out_ready holds, set by the one-bit-per-stage divider pipeline.
// A two-entry queue between classifier and divider absorbs stalls on either side.
// Reset (rst_n, asynchronous, active low) clears all valid flags; no results are pending.
module cube_map_face_uv_select_top #(
    parameter int COMPONENT_BITS = cmfs_pkg::COMPONENT_BITS_DEF,
    parameter int COORD_BITS     = cmfs_pkg::COORD_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [COMPONENT_BITS-1:0]   dir_x,
    input  logic [COMPONENT_BITS-1:0]   dir_y,
    input  logic [COMPONENT_BITS-1:0]   dir_z,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [2:0]                  face,
    output logic [COORD_BITS-1:0]       u_coord,
    output logic [COORD_BITS-1:0]       v_coord,
    output logic                        zero_vector
);

    localparam int N = COMPONENT_BITS;

    // A classified transaction: the face, the major magnitude and the two
    // minor components already chosen and negated for that face.
    typedef struct packed {
        cmfs_pkg::face_t face;
        logic            zero;
        logic [N-1:0]    ma;
        logic [N:0]      sc;
        logic [N:0]      tc;
    } cls_t;

    logic  cls_valid;
    logic  cls_ready;
    cls_t  cls_in;
    logic  q_valid;
    logic  q_ready;
    cls_t  q_out;

    // Front: takes a direction every cycle while its output is taken, picks the major axis and the face.
    cmfs_front #(
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .dir_x     (dir_x),
        .dir_y     (dir_y),
        .dir_z     (dir_z),
        .cls_valid (cls_valid),
        .cls_ready (cls_ready),
        .cls_face  (cls_in.face),
        .cls_zero  (cls_in.zero),
        .cls_ma    (cls_in.ma),
        .cls_sc    (cls_in.sc),
        .cls_tc    (cls_in.tc)
    );

    // The queue decouples the classifier from the divider so that each side
    // stalls on its own without losing the one-per-cycle rate.
    cmfs_queue #(
        .WIDTH ($bits(cls_t))
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (cls_valid),
        .push_ready (cls_ready),
        .push_data  (cls_in),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_out)
    );

    // Back: one prep stage forms sc+ma, tc+ma and 2*ma, then COORD_BITS
    // restoring steps produce both quotients in lockstep.
    cmfs_divider #(
        .COMPONENT_BITS (COMPONENT_BITS),
        .COORD_BITS     (COORD_BITS)
    ) u_divider (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (q_valid),
        .in_ready    (q_ready),
        .in_face     (q_out.face),
        .in_zero     (q_out.zero),
        .in_ma       (q_out.ma),
        .in_sc       (q_out.sc),
        .in_tc       (q_out.tc),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .face        (face),
        .u_coord     (u_coord),
        .v_coord     (v_coord),
        .zero_vector (zero_vector)
    );

endmodule

// File: dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = cmfs_pkg::COMPONENT_BITS_DEF;
    localparam int QB = cmfs_pkg::COORD_BITS_DEF;

    // The random part sends this many directions after the directed table.
    localparam int RANDOM_DIRS = 1400;

    // The drain window at the end is more than twice the depth of the pipeline.
    localparam int DRAIN_CYCLES = 2 * (QB + 2) + 8;

    // The watchdog ends the run after this many cycles with no transaction on either side.
    localparam int STALL_LIMIT = 4000;

    localparam longint COORD_MAX = (longint'(1) << QB) - 1;
    localparam int COORD_CENTER = 1 << (QB - 1);
    localparam int COORD_FULL = (1 << QB) - 1;

    typedef logic signed [CB-1:0] comp_t;

    // One result of the block: the face and its two coordinates.
    typedef struct packed {
        cmfs_pkg::face_t face;
        logic [QB-1:0]   u;
        logic [QB-1:0]   v;
        logic            zero;
    } face_uv_t;

    // One row of the directed table. When known is set, res holds the result typed
    // in by hand; otherwise the predictor supplies the expected result.
    typedef struct packed {
        comp_t     x;
        comp_t     y;
        comp_t     z;
        logic      known;
        face_uv_t  res;
    } dir_row_t;

    logic           clk;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_ready;
    logic [CB-1:0]  dir_x = '0;
    logic [CB-1:0]  dir_y = '0;
    logic [CB-1:0]  dir_z = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    logic [2:0]     face;
    logic [QB-1:0]  u_coord;
    logic [QB-1:0]  v_coord;
    logic           zero_vector;

    // Expected results, oldest first, pushed when a direction transaction is accepted.
    face_uv_t pending_coords[$];

    int dirs_sent;
    int results_checked;
    int mismatches;
    int zero_hits;
    int face_hits[6];

    // Sender pacing: the number of transactions left in the current burst.
    int burst_left;

    cube_map_face_uv_select_top #(
        .COMPONENT_BITS (CB),
        .COORD_BITS     (QB)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .dir_x       (dir_x),
        .dir_y       (dir_y),
        .dir_z       (dir_z),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .face        (face),
        .u_coord     (u_coord),
        .v_coord     (v_coord),
        .zero_vector (zero_vector)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Reset is held low at the start, released once, and never asserted again.
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // A face coordinate: (s + ma) / (2 ma) as a Q0.QB fraction, truncated toward
    // zero and clipped to the largest code, since s = ma lands exactly on 1.0.
    function automatic logic [QB-1:0] face_fraction(longint s, longint ma);
        longint t;
        longint q;
        t = s + ma;
        if (t < 0)
            t = 0;
        q = (t <<< QB) / (2 * ma);
        if (q > COORD_MAX)
            q = COORD_MAX;
        return q[QB-1:0];
    endfunction

    // Predicts the face and coordinates of one direction. The major axis is x only
    // when |x| is strictly the largest, then y when |y| > |z|, and z otherwise, so
    // ties fall to the later axis. The sign of the major component picks the face,
    // and each face takes its own pair of minor components, some of them negated.
    function automatic face_uv_t face_uv_predict(comp_t x, comp_t y, comp_t z);
        longint sx;
        longint sy;
        longint sz;
        longint ax;
        longint ay;
        longint az;
        longint ma;
        longint sc;
        longint tc;
        face_uv_t r;
        sx = longint'(x);
        sy = longint'(y);
        sz = longint'(z);
        ax = (sx < 0) ? -sx : sx;
        ay = (sy < 0) ? -sy : sy;
        az = (sz < 0) ? -sz : sz;
        if (ax > ay && ax > az)
        begin
            ma = ax;
            tc = sy;
            if (sx > 0)
            begin
                r.face = cmfs_pkg::FACE_POS_X;
                sc = sz;
            end
            else
            begin
                r.face = cmfs_pkg::FACE_NEG_X;
                sc = -sz;
            end
        end
        else if (ay > az)
        begin
            ma = ay;
            sc = sx;
            if (sy > 0)
            begin
                r.face = cmfs_pkg::FACE_POS_Y;
                tc = sz;
            end
            else
            begin
                r.face = cmfs_pkg::FACE_NEG_Y;
                tc = -sz;
            end
        end
        else
        begin
            ma = az;
            tc = sy;
            if (sz > 0)
            begin
                r.face = cmfs_pkg::FACE_POS_Z;
                sc = -sx;
            end
            else
            begin
                r.face = cmfs_pkg::FACE_NEG_Z;
                sc = sx;
            end
        end
        // A zero vector has no major magnitude to divide by; the block flags it and
        // puts both coordinates at the center of the face.
        r.zero = (ma == 0);
        if (ma == 0)
        begin
            r.u = QB'(COORD_CENTER);
            r.v = QB'(COORD_CENTER);
        end
        else
        begin
            r.u = face_fraction(sc, ma);
            r.v = face_fraction(tc, ma);
        end
        return r;
    endfunction

    function automatic dir_row_t directed_row(int x, int y, int z, logic known,
                                              cmfs_pkg::face_t f, int u, int v,
                                              logic zero);
        dir_row_t row;
        row.x = comp_t'(x);
        row.y = comp_t'(y);
        row.z = comp_t'(z);
        row.known = known;
        row.res.face = f;
        row.res.u = QB'(u);
        row.res.v = QB'(v);
        row.res.zero = zero;
        return row;
    endfunction

    // Draws one random direction. Half are uniform over the whole range; the rest
    // aim at small vectors, magnitude ties, minors just below the major
    // magnitude, and the extreme codes of each component.
    task automatic random_direction(output comp_t x, output comp_t y, output comp_t z);
        int kind;
        int m;
        int axis;
        int c[3];
        int corner_codes[7];
        corner_codes = '{-32768, -32767, -1, 0, 1, 32766, 32767};
        kind = $urandom_range(0, 99);
        if (kind < 50)
        begin
            foreach (c[i])
                c[i] = int'(comp_t'($urandom));
        end
        else if (kind < 65)
        begin
            foreach (c[i])
                c[i] = int'($urandom_range(0, 16)) - 8;
        end
        else if (kind < 80)
        begin
            // Two components share one magnitude; the third is no larger.
            m = $urandom_range(0, 32767);
            axis = $urandom_range(0, 2);
            foreach (c[i])
                c[i] = ($urandom_range(0, 1) != 0) ? -m : m;
            m = ($urandom_range(0, 3) == 0) ? m : int'($urandom_range(0, m));
            c[axis] = ($urandom_range(0, 1) != 0) ? -m : m;
        end
        else if (kind < 92)
        begin
            // A strict major axis with minors one or two below its magnitude.
            m = $urandom_range(1, 32767);
            axis = $urandom_range(0, 2);
            foreach (c[i])
            begin
                c[i] = m - int'($urandom_range(1, 2));
                if ($urandom_range(0, 1) != 0)
                    c[i] = -c[i];
            end
            c[axis] = ($urandom_range(0, 1) != 0) ? -m : m;
        end
        else
        begin
            foreach (c[i])
                c[i] = corner_codes[$urandom_range(0, 6)];
        end
        x = comp_t'(c[0]);
        y = comp_t'(c[1]);
        z = comp_t'(c[2]);
    endtask

    // Presents one direction and holds it until the block takes it. The sender
    // works in bursts: at the start of each burst it may first drop valid,
    // and about a third of the bursts follow straight on with no gap.
    task automatic send_dir(comp_t x, comp_t y, comp_t z, logic known, face_uv_t typed_res);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        dir_x <= x;
        dir_y <= y;
        dir_z <= z;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        pending_coords.push_back(known ? typed_res : face_uv_predict(x, y, z));
        dirs_sent++;
    endtask

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("[%0t] result %0d: %s", $realtime, results_checked, msg);
    endtask

    // The receiver switches between modes at random intervals: always ready,
    // a rotating 16-bit stall mask, and a coin toss per cycle. The mask always
    // keeps one ready bit, so in that mode a stall never lasts a whole rotation.
    initial
    begin : ready_pattern
        int mode;
        int span;
        logic [15:0] mask;
        span = 0;
        mode = 0;
        mask = '1;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (span == 0)
            begin
                span = $urandom_range(8, 120);
                mode = $urandom_range(0, 2);
                mask = 16'($urandom) | 16'h0001;
            end
            span--;
            case (mode)
                0: out_ready <= 1'b1;
                1:
                begin
                    out_ready <= mask[0];
                    mask = {mask[0], mask[15:1]};
                end
                default: out_ready <= ($urandom_range(0, 1) != 0);
            endcase
        end
    end

    // Every accepted result is compared, field by field, with the oldest
    // expectation. A result with nothing waiting is a failure on its own.
    always @(posedge clk)
    begin : result_check
        face_uv_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (pending_coords.size() == 0)
            begin
                report_mismatch($sformatf("no result expected, got face %0d u %0d v %0d zero %0b",
                                          face, u_coord, v_coord, zero_vector));
            end
            else
            begin
                want = pending_coords.pop_front();
                if (face !== want.face)
                    report_mismatch($sformatf("face expected %0d, got %0d", want.face, face));
                if (u_coord !== want.u)
                    report_mismatch($sformatf("u_coord expected %0d, got %0d", want.u, u_coord));
                if (v_coord !== want.v)
                    report_mismatch($sformatf("v_coord expected %0d, got %0d", want.v, v_coord));
                if (zero_vector !== want.zero)
                    report_mismatch($sformatf("zero_vector expected %0b, got %0b",
                                              want.zero, zero_vector));
                if (want.face <= cmfs_pkg::FACE_NEG_Z)
                    face_hits[want.face]++;
                if (want.zero)
                    zero_hits++;
            end
            results_checked++;
        end
    end

    // The watchdog counts cycles in which neither channel moves a transaction.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        wait (rst_n === 1'b1);
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending_coords.size());
        $display("cube_map_face_uv_select_top regression: fail");
        $finish;
    end

    // Directed table first, then the random directions, then the drain.
    initial
    begin : stimulus
        dir_row_t rows[$];
        comp_t rx;
        comp_t ry;
        comp_t rz;
        face_uv_t unused_res;
        unused_res = '0;
        burst_left = 0;

        // The zero vector goes down the z branch to -z with the center coordinates.
        rows.push_back(directed_row(0, 0, 0, 1'b1, cmfs_pkg::FACE_NEG_Z,
                                    COORD_CENTER, COORD_CENTER, 1'b1));
        // Vectors along an axis, at both extremes, hit the center of each face.
        rows.push_back(directed_row(32767, 0, 0, 1'b1, cmfs_pkg::FACE_POS_X,
                                    COORD_CENTER, COORD_CENTER, 1'b0));
        rows.push_back(directed_row(-32768, 0, 0, 1'b1, cmfs_pkg::FACE_NEG_X,
                                    COORD_CENTER, COORD_CENTER, 1'b0));
        rows.push_back(directed_row(0, 32767, 0, 1'b1, cmfs_pkg::FACE_POS_Y,
                                    COORD_CENTER, COORD_CENTER, 1'b0));
        rows.push_back(directed_row(0, -32768, 0, 1'b1, cmfs_pkg::FACE_NEG_Y,
                                    COORD_CENTER, COORD_CENTER, 1'b0));
        rows.push_back(directed_row(0, 0, 32767, 1'b1, cmfs_pkg::FACE_POS_Z,
                                    COORD_CENTER, COORD_CENTER, 1'b0));
        rows.push_back(directed_row(0, 0, -32768, 1'b1, cmfs_pkg::FACE_NEG_Z,
                                    COORD_CENTER, COORD_CENTER, 1'b0));
        rows.push_back(directed_row(1, 0, 0, 1'b1, cmfs_pkg::FACE_POS_X,
                                    COORD_CENTER, COORD_CENTER, 1'b0));
        // An x/y tie goes to y, and sc equal to the major magnitude clips to full scale.
        rows.push_back(directed_row(32767, 32767, 0, 1'b1, cmfs_pkg::FACE_POS_Y,
                                    COORD_FULL, COORD_CENTER, 1'b0));
        // A three-way tie goes to z; here u bottoms out and v clips.
        rows.push_back(directed_row(5, 5, 5, 1'b1, cmfs_pkg::FACE_POS_Z,
                                    0, COORD_FULL, 1'b0));
        // A y/z tie goes to z.
        rows.push_back(directed_row(0, -7, 7, 1'b1, cmfs_pkg::FACE_POS_Z,
                                    COORD_CENTER, 0, 1'b0));
        rows.push_back(directed_row(-32768, -32768, -32768, 1'b1, cmfs_pkg::FACE_NEG_Z,
                                    0, 0, 1'b0));
        rows.push_back(directed_row(-1, -1, -1, 1'b1, cmfs_pkg::FACE_NEG_Z, 0, 0, 1'b0));
        // Off-axis directions on every face, with truncating quotients.
        rows.push_back(directed_row(3, 1, -2, 1'b0, cmfs_pkg::FACE_POS_X, 0, 0, 1'b0));
        rows.push_back(directed_row(-1000, 300, -999, 1'b0, cmfs_pkg::FACE_POS_X, 0, 0, 1'b0));
        rows.push_back(directed_row(100, -200, 50, 1'b0, cmfs_pkg::FACE_POS_X, 0, 0, 1'b0));
        rows.push_back(directed_row(7, 3, -20, 1'b0, cmfs_pkg::FACE_POS_X, 0, 0, 1'b0));
        rows.push_back(directed_row(-32768, 32767, 1, 1'b0, cmfs_pkg::FACE_POS_X,
                                    0, 0, 1'b0));
        rows.push_back(directed_row(12345, -12345, 0, 1'b0, cmfs_pkg::FACE_POS_X,
                                    0, 0, 1'b0));
        rows.push_back(directed_row(-200, 30000, -29999, 1'b0, cmfs_pkg::FACE_POS_X,
                                    0, 0, 1'b0));
        rows.push_back(directed_row(0, -32768, 32767, 1'b0, cmfs_pkg::FACE_POS_X,
                                    0, 0, 1'b0));
        rows.push_back(directed_row(-21, 4, 22, 1'b0, cmfs_pkg::FACE_POS_X, 0, 0, 1'b0));

        wait (rst_n === 1'b1);
        @(posedge clk);

        foreach (rows[i])
            send_dir(rows[i].x, rows[i].y, rows[i].z, rows[i].known, rows[i].res);

        repeat (RANDOM_DIRS)
        begin
            random_direction(rx, ry, rz);
            send_dir(rx, ry, rz, 1'b0, unused_res);
        end
        in_valid <= 1'b0;

        // Wait for every expected result, then give the pipeline time to show any
        // extra result it should not produce.
        while (pending_coords.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d directions and checked %0d results, %0d zero vectors among them.",
                 dirs_sent, results_checked, zero_hits);
        $display("Results per face +x %0d, -x %0d, +y %0d, -y %0d, +z %0d, -z %0d; %0d mismatches.",
                 face_hits[0], face_hits[1], face_hits[2], face_hits[3], face_hits[4],
                 face_hits[5], mismatches);
        if (mismatches == 0)
            $display("cube_map_face_uv_select_top regression: pass");
        else
            $display("cube_map_face_uv_select_top regression: fail");
        $finish;
    end

endmodule

// File: files.f
hdl/cmfs_pkg.sv
hdl/cmfs_front.sv
hdl/cmfs_queue.sv
hdl/cmfs_divider.sv
hdl/cube_map_face_uv_select_top.sv
dv/tb_top.sv
